>>> rtl/core/rbf_pkg.sv
// Package for the ring buffer FIFO: shared widths, input kind codes,
// datapath operation codes and the controller/datapath command and status structs.
// No dependencies.
package rbf_pkg;

    localparam int CAP_W  = 7;
    localparam int CNT_W  = 6;
    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_BURST = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        OP_NONE        = 3'd0,
        OP_WRITE       = 3'd1,
        OP_READ        = 3'd2,
        OP_BURST_FIRST = 3'd3,
        OP_BURST_NEXT  = 3'd4,
        OP_FAIL        = 3'd5
    } t_op;

    typedef struct packed {
        logic load;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic empty;
        logic burst_none;
        logic burst_single;
        logic rem_last;
        logic rem_nonzero;
    } t_status;

endpackage

>>> rtl/core/rbf_datapath.sv
// Ring buffer FIFO datapath: storage array, indices, capacity register,
// write run and burst counters, output word register. Uses rbf_pkg.
module rbf_datapath import rbf_pkg::*; #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CAP_W-1:0]  i_cfg_wdata,
    input  logic [BYTE_W-1:0] i_write_data,
    input  logic              i_burst_start,
    input  logic [CNT_W-1:0]  i_read_length,
    input  logic              i_out_ready,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    output logic              o_out_valid,
    output logic              o_ok,
    output logic [BYTE_W-1:0] o_read_data,
    output logic              o_last,
    output logic [CNT_W-1:0]  o_count,
    output logic [CNT_W-1:0]  o_held_count,
    output logic [CNT_W-1:0]  o_free_count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int MIN_W = (DATA_WIDTH < BYTE_W) ? DATA_WIDTH : BYTE_W;
    localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(DEPTH);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_word;

    logic [CAP_W-1:0] r_capacity;
    logic [IDX_W-1:0] r_read_index;
    logic [IDX_W-1:0] r_write_index;
    logic [CNT_W-1:0] r_run_count;
    logic [CNT_W-1:0] r_remaining;
    logic [CNT_W-1:0] r_bcount;

    logic             r_out_valid;
    logic             r_ok;
    logic             r_rd;
    logic             r_last;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_used;
    logic [CNT_W-1:0] r_free;

    logic [CAP_W-1:0] rd_ext;
    logic [CAP_W-1:0] wr_ext;
    logic [CAP_W-1:0] rd_inc;
    logic [CAP_W-1:0] wr_inc;
    logic [IDX_W-1:0] rd_next;
    logic [IDX_W-1:0] wr_next;
    logic [CAP_W-1:0] used_now;
    logic [CAP_W-1:0] used_after;
    logic [CAP_W-1:0] free_after;
    logic [CAP_W-1:0] len_ext;
    logic [CAP_W-1:0] burst_n;
    logic             full;
    logic             rd_en;
    logic             wr_en;
    logic             out_free;
    logic [CNT_W-1:0] run_base;
    logic [CNT_W-1:0] run_inc;
    logic [CNT_W-1:0] n_run;
    logic             n_ok;
    logic             n_rd;
    logic             n_last;
    logic [CNT_W-1:0] n_count;
    logic             cfg_ok;
    logic [CAP_W-1:0] cfg_cap;
    logic [DATA_WIDTH-1:0] w_word;
    logic [BYTE_W-1:0]     rd_byte;

    // fill level and wrap arithmetic
    always_comb begin
        rd_ext   = CAP_W'(r_read_index);
        wr_ext   = CAP_W'(r_write_index);
        rd_inc   = rd_ext + CAP_W'(1);
        wr_inc   = wr_ext + CAP_W'(1);
        rd_next  = (rd_inc >= r_capacity) ? '0 : rd_inc[IDX_W-1:0];
        wr_next  = (wr_inc >= r_capacity) ? '0 : wr_inc[IDX_W-1:0];
        full     = (wr_next == r_read_index);
        used_now = (wr_ext >= rd_ext) ? (wr_ext - rd_ext) : (wr_ext + r_capacity - rd_ext);
        len_ext  = CAP_W'(i_read_length);
        burst_n  = (len_ext > used_now) ? used_now : len_ext;
        run_base = i_burst_start ? '0 : r_run_count;
        run_inc  = run_base + CNT_W'(run_base != '1);
        n_run    = full ? run_base : run_inc;
        out_free = !r_out_valid || i_out_ready;
        cfg_ok   = (i_cfg_wdata >= CAP_W'(2));
        cfg_cap  = (i_cfg_wdata > CAP_MAX) ? CAP_MAX : i_cfg_wdata;
        wr_en    = (i_cmd.op == OP_WRITE) && !full;
        rd_en    = (i_cmd.op == OP_READ) || (i_cmd.op == OP_BURST_FIRST) ||
                   (i_cmd.op == OP_BURST_NEXT);
        w_word   = '0;
        w_word[MIN_W-1:0] = i_write_data[MIN_W-1:0];
    end

    always_comb begin
        o_status.out_free     = out_free;
        o_status.empty        = (r_read_index == r_write_index);
        o_status.burst_none   = (burst_n == '0);
        o_status.burst_single = (burst_n == CAP_W'(1));
        o_status.rem_last     = (r_remaining == CNT_W'(1));
        o_status.rem_nonzero  = (r_remaining != '0);
    end

    // result fields for the word being loaded
    always_comb begin
        n_ok       = 1'b0;
        n_rd       = 1'b0;
        n_last     = 1'b1;
        n_count    = '0;
        used_after = used_now;
        case (i_cmd.op)
            OP_WRITE: begin
                n_ok       = !full;
                n_count    = n_run;
                used_after = used_now + CAP_W'(!full);
            end
            OP_READ: begin
                n_ok       = 1'b1;
                n_rd       = 1'b1;
                n_count    = CNT_W'(1);
                used_after = used_now - CAP_W'(1);
            end
            OP_BURST_FIRST: begin
                n_ok       = 1'b1;
                n_rd       = 1'b1;
                n_last     = o_status.burst_single;
                n_count    = CNT_W'(1);
                used_after = used_now - CAP_W'(1);
            end
            OP_BURST_NEXT: begin
                n_ok       = 1'b1;
                n_rd       = 1'b1;
                n_last     = o_status.rem_last;
                n_count    = r_bcount + CNT_W'(1);
                used_after = used_now - CAP_W'(1);
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
        free_after = r_capacity - CAP_W'(1) - used_after;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity    <= CAP_MAX;
            r_read_index  <= '0;
            r_write_index <= '0;
            r_run_count   <= '0;
            r_remaining   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we && cfg_ok) begin
                r_capacity    <= cfg_cap;
                r_read_index  <= '0;
                r_write_index <= '0;
                r_run_count   <= '0;
            end else begin
                case (i_cmd.op)
                    OP_WRITE: begin
                        r_run_count <= n_run;
                        if (!full) begin
                            r_write_index <= wr_next;
                        end
                    end
                    OP_READ: begin
                        r_read_index <= rd_next;
                    end
                    OP_BURST_FIRST: begin
                        r_read_index <= rd_next;
                        r_remaining  <= CNT_W'(burst_n - CAP_W'(1));
                    end
                    OP_BURST_NEXT: begin
                        r_read_index <= rd_next;
                        r_remaining  <= r_remaining - CNT_W'(1);
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ok    <= n_ok;
            r_rd    <= n_rd;
            r_last  <= n_last;
            r_count <= n_count;
            r_used  <= used_after[CNT_W-1:0];
            r_free  <= free_after[CNT_W-1:0];
        end
        if (i_cmd.op == OP_BURST_FIRST) begin
            r_bcount <= CNT_W'(1);
        end else if (i_cmd.op == OP_BURST_NEXT) begin
            r_bcount <= r_bcount + CNT_W'(1);
        end
    end

    // storage, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_write_index] <= w_word;
        end
        if (rd_en) begin
            r_rd_word <= r_mem[r_read_index];
        end
    end

    always_comb begin
        rd_byte = '0;
        rd_byte[MIN_W-1:0] = r_rd_word[MIN_W-1:0];
    end

    assign o_out_valid  = r_out_valid;
    assign o_ok         = r_ok;
    assign o_read_data  = r_rd ? rd_byte : '0;
    assign o_last       = r_last;
    assign o_count      = r_count;
    assign o_held_count = r_used;
    assign o_free_count = r_free;

    a_read_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CAP_W'(r_read_index) < r_capacity)
        else $error("read index beyond capacity");

    a_write_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CAP_W'(r_write_index) < r_capacity)
        else $error("write index beyond capacity");

    a_capacity_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_capacity >= CAP_W'(2)) && (r_capacity <= CAP_MAX))
        else $error("capacity out of range");

    a_no_read_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> !o_status.empty)
        else $error("read issued on empty buffer");

endmodule

>>> rtl/core/rbf_controller.sv
// Ring buffer FIFO controller: accepts input words and sequences burst reads,
// issuing one datapath operation per cycle while the output register is free. Uses rbf_pkg.
module rbf_controller import rbf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [KIND_W-1:0] i_kind,
    input  t_status           i_status,
    output logic              o_in_ready,
    output t_cmd              o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_BURST = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    t_op    op;

    always_comb begin
        n_state    = r_state;
        op         = OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = i_status.out_free;
                if (i_in_valid && i_status.out_free) begin
                    case (t_kind'(i_kind))
                        KIND_WRITE: op = OP_WRITE;
                        KIND_READ:  op = i_status.empty ? OP_FAIL : OP_READ;
                        KIND_BURST: begin
                            if (i_status.burst_none) begin
                                op = OP_FAIL;
                            end else begin
                                op = OP_BURST_FIRST;
                                if (!i_status.burst_single) begin
                                    n_state = ST_BURST;
                                end
                            end
                        end
                        default: op = OP_FAIL;
                    endcase
                end
            end
            ST_BURST: begin
                if (i_status.out_free) begin
                    op = OP_BURST_NEXT;
                    if (i_status.rem_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
        o_cmd.op   = op;
        o_cmd.load = (op != OP_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_burst_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BURST) |-> i_status.rem_nonzero)
        else $error("burst state with nothing left");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> i_status.out_free)
        else $error("output loaded while occupied");

    a_burst_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_BURST) |-> $past(op == OP_BURST_FIRST))
        else $error("burst entered without first beat");

endmodule

>>> rtl/core/ring_buffer_fifo.sv
// Circular byte FIFO with one slot kept empty to tell full from empty: it holds up
// to capacity-1 words, indices wrap at capacity (2..DEPTH, reset DEPTH; a write of
// 0 or 1 is ignored, larger values saturate, any accepted write empties the buffer).
// Single writes and single reads may follow back to back while the output register
// is free. A burst read of n words (length clamped to the fill level) moves one word
// per cycle through the single storage read port while the output register is free;
// no new input word is taken until its last word has been loaded into the output
// register. Every result carries the fill level and free space after it. Storage needs
// no clearing after reset. Uses rbf_pkg, rbf_controller and rbf_datapath.
module ring_buffer_fifo import rbf_pkg::*; #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CAP_W-1:0]  i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [BYTE_W-1:0] i_write_data,
    input  logic              i_burst_start,
    input  logic [CNT_W-1:0]  i_read_length,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_ok,
    output logic [BYTE_W-1:0] o_read_data,
    output logic              o_last,
    output logic [CNT_W-1:0]  o_count,
    output logic [CNT_W-1:0]  o_held_count,
    output logic [CNT_W-1:0]  o_free_count
);

    t_cmd    cmd;
    t_status status;

    rbf_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    rbf_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_write_data  (i_write_data),
        .i_burst_start (i_burst_start),
        .i_read_length (i_read_length),
        .i_out_ready   (i_out_ready),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .o_ok          (o_ok),
        .o_read_data   (o_read_data),
        .o_last        (o_last),
        .o_count       (o_count),
        .o_held_count  (o_held_count),
        .o_free_count  (o_free_count)
    );

endmodule

>>> test/tb_top.sv
// Self-checking bench for ring_buffer_fifo: a queue-fed driver and a result monitor
// check every word against an in-bench model of the circular FIFO.
// Depends on rbf_pkg and ring_buffer_fifo.
module tb_top import rbf_pkg::*;;

    localparam int FIFO_DEPTH = 64;

    typedef struct {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
        logic              start;
        logic [CNT_W-1:0]  len;
        bit                hold;
    } t_fifo_word;

    typedef struct {
        logic              ok;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [CNT_W-1:0]  cnt;
        logic [CNT_W-1:0]  used;
        logic [CNT_W-1:0]  free;
    } t_fifo_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CAP_W-1:0]  i_cfg_wdata = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [KIND_W-1:0] i_kind = '0;
    logic [BYTE_W-1:0] i_write_data = '0;
    logic              i_burst_start = 1'b0;
    logic [CNT_W-1:0]  i_read_length = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_ok;
    logic [BYTE_W-1:0] o_read_data;
    logic              o_last;
    logic [CNT_W-1:0]  o_count;
    logic [CNT_W-1:0]  o_held_count;
    logic [CNT_W-1:0]  o_free_count;

    ring_buffer_fifo #(.DEPTH(FIFO_DEPTH), .DATA_WIDTH(8)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_write_data  (i_write_data),
        .i_burst_start (i_burst_start),
        .i_read_length (i_read_length),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_ok          (o_ok),
        .o_read_data   (o_read_data),
        .o_last        (o_last),
        .o_count       (o_count),
        .o_held_count  (o_held_count),
        .o_free_count  (o_free_count)
    );

    always #10 i_clk = ~i_clk;

    // FIFO model state
    logic [BYTE_W-1:0] fifo_mem [FIFO_DEPTH];
    int                rd_ptr = 0;
    int                wr_ptr = 0;
    int                run_cnt = 0;
    int                fifo_cap = FIFO_DEPTH;

    t_fifo_word   pend_q[$];
    t_fifo_result expect_q[$];
    t_fifo_word   cur_word;

    int n_queued = 0;
    int n_words_acc = 0;
    int n_res_exp = 0;
    int n_res_got = 0;
    int n_err = 0;
    int burst_left = 1;
    int gap_left = 0;
    int stall_left = 0;
    int rx_mode = 0;
    int rx_cycles = 0;

    function automatic int fill_level();
        return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : wr_ptr + fifo_cap - rd_ptr;
    endfunction

    function automatic int next_ptr(int p);
        return (p + 1 >= fifo_cap) ? 0 : p + 1;
    endfunction

    function automatic void push_result(logic ok, logic [BYTE_W-1:0] d, logic last, int cnt);
        t_fifo_result r;
        int           used;
        used = fill_level();
        r.ok   = ok;
        r.data = d;
        r.last = last;
        r.cnt  = CNT_W'(cnt);
        r.used = CNT_W'(used);
        r.free = CNT_W'(fifo_cap - 1 - used);
        expect_q.push_back(r);
    endfunction

    function automatic void capacity_write(logic [CAP_W-1:0] v);
        if (v >= 2) begin
            fifo_cap = (v > FIFO_DEPTH) ? FIFO_DEPTH : int'(v);
            rd_ptr   = 0;
            wr_ptr   = 0;
            run_cnt  = 0;
        end
    endfunction

    // returns the number of results the word causes
    function automatic int fifo_predict(t_fifo_word w);
        int n;
        int nxt;
        logic [BYTE_W-1:0] d;
        case (w.kind)
            KIND_WRITE: begin
                nxt = next_ptr(wr_ptr);
                if (w.start) begin
                    run_cnt = 0;
                end
                if (nxt != rd_ptr) begin
                    fifo_mem[wr_ptr] = w.data;
                    wr_ptr = nxt;
                    if (run_cnt < 63) begin
                        run_cnt++;
                    end
                    push_result(1'b1, '0, 1'b1, run_cnt);
                end else begin
                    push_result(1'b0, '0, 1'b1, run_cnt);
                end
                return 1;
            end
            KIND_READ: begin
                if (rd_ptr == wr_ptr) begin
                    push_result(1'b0, '0, 1'b1, 0);
                end else begin
                    d = fifo_mem[rd_ptr];
                    rd_ptr = next_ptr(rd_ptr);
                    push_result(1'b1, d, 1'b1, 1);
                end
                return 1;
            end
            KIND_BURST: begin
                n = (int'(w.len) > fill_level()) ? fill_level() : int'(w.len);
                if (n == 0) begin
                    push_result(1'b0, '0, 1'b1, 0);
                    return 1;
                end
                for (int k = 0; k < n; k++) begin
                    d = fifo_mem[rd_ptr];
                    rd_ptr = next_ptr(rd_ptr);
                    push_result(1'b1, d, k + 1 == n, k + 1);
                end
                return n;
            end
            default: begin
                push_result(1'b0, '0, 1'b1, 0);
                return 1;
            end
        endcase
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            n_err++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // driver
    always @(posedge i_clk) begin : drv
        int nres;
        bit take;
        take = i_in_valid && o_in_ready;
        nres = 0;
        if (take) begin
            nres = fifo_predict(cur_word);
            n_words_acc <= n_words_acc + 1;
            n_res_exp   <= n_res_exp + nres;
        end
        if (!i_in_valid || take) begin
            if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pend_q.size() != 0 &&
                         !(pend_q[0].hold && n_res_exp + nres != n_res_got)) begin
                cur_word = pend_q[0];
                pend_q.delete(0);
                i_in_valid    <= 1'b1;
                i_kind        <= cur_word.kind;
                i_write_data  <= cur_word.data;
                i_burst_start <= cur_word.start;
                i_read_length <= cur_word.len;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin : mon
        t_fifo_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_res_got <= n_res_got + 1;
            if (expect_q.size() == 0) begin
                n_err++;
                $display("%0t: unexpected word, expected none, actual ok=%0d data=%0d",
                         $time, o_ok, o_read_data);
            end else begin
                want = expect_q[0];
                expect_q.delete(0);
                check_field("ok", want.ok, o_ok);
                check_field("read_data", want.data, o_read_data);
                check_field("last", want.last, o_last);
                check_field("count", want.cnt, o_count);
                check_field("held_count", want.used, o_held_count);
                check_field("free_count", want.free, o_free_count);
            end
        end
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 3) != 0);
                default: begin
                    if ($urandom_range(0, 9) == 0) begin
                        i_out_ready <= 1'b0;
                        stall_left  <= $urandom_range(1, 8);
                    end else begin
                        i_out_ready <= 1'b1;
                    end
                end
            endcase
        end
        if (rx_cycles == 0) begin
            rx_mode   <= $urandom_range(0, 2);
            rx_cycles <= $urandom_range(50, 300);
        end else begin
            rx_cycles <= rx_cycles - 1;
        end
    end

    task automatic queue_word(t_kind k, logic [BYTE_W-1:0] d, logic s, logic [CNT_W-1:0] len,
                              bit hold);
        t_fifo_word w;
        w.kind  = k;
        w.data  = d;
        w.start = s;
        w.len   = len;
        w.hold  = hold;
        pend_q.push_back(w);
        n_queued++;
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (n_words_acc != n_queued || n_res_exp != n_res_got) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        capacity_write(v);
    endtask

    function automatic logic [BYTE_W-1:0] rnd_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CNT_W-1:0] rnd_len();
        return CNT_W'($urandom_range(0, 63));
    endfunction

    initial begin : stim
        int made;
        int phase;
        int sel;
        int n;
        logic [CAP_W-1:0] cap_val;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset capacity, empty cases, unused kind, clamped burst
        queue_word(KIND_READ, 8'h00, 1'b0, 6'd0, 1'b0);
        queue_word(KIND_BURST, 8'h00, 1'b0, 6'd5, 1'b0);
        queue_word(KIND_NONE, 8'hFF, 1'b1, 6'd63, 1'b0);
        queue_word(KIND_WRITE, 8'h00, 1'b1, 6'd0, 1'b0);
        queue_word(KIND_WRITE, 8'hFF, 1'b0, 6'd63, 1'b0);
        queue_word(KIND_WRITE, 8'hA5, 1'b0, 6'd0, 1'b0);
        queue_word(KIND_BURST, 8'h00, 1'b0, 6'd0, 1'b0);
        queue_word(KIND_BURST, 8'hFF, 1'b1, 6'd63, 1'b0);
        queue_word(KIND_READ, 8'h00, 1'b0, 6'd0, 1'b0);
        queue_word(KIND_WRITE, 8'h5A, 1'b1, 6'd0, 1'b0);
        wait_drained();
        set_capacity(7'd0);
        set_capacity(7'd2);
        // smallest capacity: one word fills it
        queue_word(KIND_WRITE, 8'h11, 1'b1, 6'd0, 1'b0);
        queue_word(KIND_WRITE, 8'h22, 1'b0, 6'd0, 1'b0);
        queue_word(KIND_READ, 8'h00, 1'b0, 6'd0, 1'b0);
        queue_word(KIND_READ, 8'h00, 1'b0, 6'd0, 1'b0);
        queue_word(KIND_WRITE, 8'h33, 1'b0, 6'd0, 1'b0);
        queue_word(KIND_WRITE, 8'h44, 1'b0, 6'd0, 1'b0);
        queue_word(KIND_BURST, 8'h00, 1'b0, 6'd1, 1'b0);
        wait_drained();
        set_capacity(7'd127);
        set_capacity(7'd1);

        made = 0;
        phase = 0;
        while (made < 500) begin
            wait_drained();
            case (phase)
                0: cap_val = 7'd64;
                1: cap_val = 7'd2;
                2: cap_val = 7'd127;
                default: begin
                    sel = $urandom_range(0, 9);
                    case (sel)
                        0: cap_val = 7'd2;
                        1: cap_val = 7'd3;
                        2: cap_val = 7'd64;
                        3: cap_val = CAP_W'($urandom_range(65, 127));
                        4: cap_val = CAP_W'($urandom_range(0, 1));
                        default: cap_val = CAP_W'($urandom_range(4, 63));
                    endcase
                end
            endcase
            set_capacity(cap_val);
            n = 0;
            if (phase == 0) begin
                // long write run with reads between: run count saturates
                queue_word(KIND_WRITE, rnd_byte(), 1'b1, rnd_len(), 1'b0);
                for (int i = 0; i < 80; i++) begin
                    queue_word(KIND_WRITE, rnd_byte(), 1'b0, rnd_len(), 1'b0);
                    queue_word(KIND_READ, rnd_byte(), 1'($urandom_range(0, 1)), rnd_len(),
                               1'b0);
                end
                n = 161;
            end
            while (n < 70) begin
                sel = $urandom_range(0, 9);
                if (sel < 4) begin
                    for (int i = $urandom_range(1, fifo_cap + 1); i > 0; i--) begin
                        queue_word(KIND_WRITE, rnd_byte(),
                                   (n == 0 || $urandom_range(0, 15) == 0) &&
                                   $urandom_range(0, 3) != 0,
                                   rnd_len(), (phase == 1 && n == 0) ||
                                   $urandom_range(0, 49) == 0);
                        n++;
                    end
                end else if (sel < 7) begin
                    queue_word(KIND_BURST, rnd_byte(), 1'($urandom_range(0, 1)),
                               ($urandom_range(0, 3) == 0) ? rnd_len() :
                               CNT_W'($urandom_range(1, fifo_cap - 1)),
                               $urandom_range(0, 49) == 0);
                    n++;
                end else if (sel < 9) begin
                    for (int i = $urandom_range(1, 3); i > 0; i--) begin
                        queue_word(KIND_READ, rnd_byte(), 1'($urandom_range(0, 1)), rnd_len(),
                                   $urandom_range(0, 49) == 0);
                        n++;
                    end
                end else begin
                    queue_word(t_kind'($urandom_range(0, 3)), rnd_byte(),
                               1'($urandom_range(0, 1)), rnd_len(), 1'b0);
                    n++;
                end
            end
            made += n;
            phase++;
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (n_err == 0) begin
            $display("PASS ring_buffer_fifo");
        end else begin
            $display("FAIL ring_buffer_fifo");
        end
        $finish;
    end

    initial begin : watchdog
        #30_000_000;
        $display("FAIL ring_buffer_fifo");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/rbf_pkg.sv
rtl/core/rbf_datapath.sv
rtl/core/rbf_controller.sv
rtl/core/ring_buffer_fifo.sv
test/tb_top.sv
